// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define IDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property on every edge, reset included.
`define IDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/idc_pkg.sv
package idc_pkg;

  localparam int TS_W  = 48;
  localparam int TAG_W = 32;
  localparam int POS_W = 10;
  localparam int E_W   = 16;
  localparam int HM_W  = 8;
  localparam int CNT_W = 7;
  localparam int IN_W  = 168;
  localparam int OUT_W = 144;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam int HM_LOW   = 0;
  localparam int HM_HIGH  = 1;
  localparam int HM_PIN1  = 2;
  localparam int HM_PIN2  = 3;
  localparam int HM_VETOF = 4;
  localparam int HM_VETOR = 5;
  localparam int HM_SIPM  = 6;
  localparam int HM_CLOV  = 7;

  typedef enum logic [3:0] {
    STAT_BADTIME    = 4'd0,
    STAT_IMPLANT    = 4'd1,
    STAT_IMP_BADPOS = 4'd2,
    STAT_DEC_BADPOS = 4'd3,
    STAT_CORRELATED = 4'd4,
    STAT_NONE       = 4'd5,
    STAT_CLOVER     = 4'd6,
    STAT_LIGHT      = 4'd7,
    STAT_UNKNOWN    = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    REG_PIN1_TH  = 2'd0,
    REG_PIN2_TH  = 2'd1,
    REG_CORR_WIN = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLASS,
    ST_IMP,
    ST_NB,
    ST_NB_META,
    ST_SCAN,
    ST_NB_WB,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic [TS_W-1:0]         time_ns;
    logic signed [POS_W-1:0] x_q4;
    logic signed [POS_W-1:0] y_q4;
    logic [TAG_W-1:0]        tag;
  } ring_entry_t;

  typedef struct packed {
    logic implant;
    logic decay;
    logic clover;
    logic light;
  } evt_class_t;

  function automatic logic [TS_W-1:0] tdiff(input logic [TS_W-1:0] a,
                                             input logic [TS_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // q4 position to pixel coordinate, truncating toward zero
  function automatic logic signed [7:0] trunc_q4(input logic signed [POS_W-1:0] q);
    logic [POS_W-1:0] mag;
    logic [7:0]       t;
    mag = q[POS_W-1] ? POS_W'(-q) : q;
    t   = 8'(mag >> 4);
    return q[POS_W-1] ? -signed'(t) : signed'(t);
  endfunction

endpackage

// File: rtl/idc_classify.sv
module idc_classify (
  input  logic [idc_pkg::HM_W-1:0] hit_mask,
  input  logic [idc_pkg::E_W-1:0]  pin1_energy,
  input  logic [idc_pkg::E_W-1:0]  pin2_energy,
  input  logic [idc_pkg::E_W-1:0]  pin1_th,
  input  logic [idc_pkg::E_W-1:0]  pin2_th,
  output idc_pkg::evt_class_t      cls
);
  import idc_pkg::*;

  logic low, high, p1, p2, vf, vr, sipm, clov;
  logic any_pin, pin_imp, pin_light, is_light;

  always_comb begin
    low       = hit_mask[HM_LOW];
    high      = hit_mask[HM_HIGH];
    p1        = hit_mask[HM_PIN1];
    p2        = hit_mask[HM_PIN2];
    vf        = hit_mask[HM_VETOF];
    vr        = hit_mask[HM_VETOR];
    sipm      = hit_mask[HM_SIPM];
    clov      = hit_mask[HM_CLOV];
    any_pin   = p1 | p2;
    pin_imp   = p1 & (pin1_energy > pin1_th) & p2 & (pin2_energy > pin2_th);
    pin_light = p1 & !(pin1_energy > pin1_th) & p2 & !(pin2_energy > pin2_th);
    is_light  = (low | high) & (pin_light | vf | vr | sipm);
    cls.implant = low & pin_imp & !vr;
    cls.decay   = high & !any_pin & !is_light;
    cls.clover  = !any_pin & !high & !low & clov;
    cls.light   = is_light;
  end

endmodule

// File: rtl/idc_pixel_mem.sv
module idc_pixel_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 104
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/idc_ring_mem.sv
module idc_ring_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  idc_pkg::ring_entry_t wr_data,
  input  logic [AW-1:0]        rd_addr,
  output idc_pkg::ring_entry_t rd_data
);
  import idc_pkg::*;

  ring_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/implant_decay_correlator_unit.sv
// Path from input transfer to out_tvalid: ST_CLASS, ST_DONE and the output register for badtime,
// bad position, clover, light and unknown events, with ST_IMP after ST_CLASS for an implant;
// clear_grid runs the GRID*GRID sweep first. Decay: ST_CLASS, then per in-grid neighbor ST_NB,
// ST_NB_META, ST_SCAN (one read per list entry) and ST_NB_WB, and ST_NB alone per off-grid neighbor.
// One item in flight; ST_DONE waits on a stalled output, and in_tready rises as the result is registered.
// Reset (rst_n low, synchronous) and clear_grid sweep all GRID*GRID pixels, zeroing the pixel memory.
`include "assert_macros.svh"

module implant_decay_correlator_unit #(
  parameter int GRID       = 16,
  parameter int CORR_WIN   = 3,
  parameter int LIST_DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // clear_grid, timestamp_ns, hit_mask, pin1_energy, pin2_energy,
  // low_x_q4, low_y_q4, high_x_q4, high_y_q4, ion_tag, zero pad
  input  logic [idc_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status, correlated_count, matched_tag, matched_time, dt_last_ion, zero pad
  output logic [idc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  idc_pkg::reg_idx_t          cfg_index,
  input  logic [idc_pkg::TS_W-1:0]   cfg_data
);
  import idc_pkg::*;

  localparam int NPIX  = GRID * GRID;
  localparam int XW    = $clog2(GRID);
  localparam int PW    = $clog2(NPIX);
  localparam int RDEP  = NPIX * LIST_DEPTH;
  localparam int RAW   = (RDEP > 1) ? $clog2(RDEP) : 1;
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int HW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int SW    = CW + 1;
  localparam int MW    = 2 * TS_W + 1 + CW + HW;
  localparam int LIM   = (CORR_WIN - 1) / 2;
  localparam int WS    = 2 * LIM + 1;
  localparam int DW    = $clog2(WS) + 1;
  localparam logic [21:0] R2 = 22'(256 * LIM * LIM);

  function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] h, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(k);
    if (s >= SW'(LIST_DEPTH)) begin
      s = s - SW'(LIST_DEPTH);
    end
    return HW'(s);
  endfunction

  function automatic logic in_grid(input logic signed [7:0] p);
    return (p >= 8'sd0) && (p < 8'(GRID));
  endfunction

  function automatic logic [PW-1:0] pix_of(input logic signed [7:0] x,
                                           input logic signed [7:0] y);
    return PW'(PW'(x[XW-1:0]) * PW'(GRID) + PW'(y[XW-1:0]));
  endfunction

  function automatic logic [RAW-1:0] raddr(input logic [PW-1:0] p, input logic [HW-1:0] s);
    return RAW'(RAW'(p) * RAW'(LIST_DEPTH) + RAW'(s));
  endfunction

  fsm_t state_r, state_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic clr_item_r, clr_item_nxt;

  logic [E_W-1:0]  pin1_th_r, pin2_th_r;
  logic [TS_W-1:0] win_r;

  logic [TS_W-1:0]         ts_r, ts_nxt;
  logic [HM_W-1:0]         hm_r, hm_nxt;
  logic [E_W-1:0]          e1_r, e1_nxt, e2_r, e2_nxt;
  logic signed [POS_W-1:0] lx_r, lx_nxt, ly_r, ly_nxt, hx_r, hx_nxt, hy_r, hy_nxt;
  logic [TAG_W-1:0]        tag_r, tag_nxt;

  logic signed [7:0] px_r, px_nxt, py_r, py_nxt;
  logic [DW-1:0]     di_r, di_nxt, dj_r, dj_nxt;
  logic [PW-1:0]     pix_r, pix_nxt;
  logic [CW-1:0]     n_r, n_nxt, k_r, k_nxt, keep_r, keep_nxt;
  logic [HW-1:0]     h_r, h_nxt;
  logic              ev_r, ev_nxt;
  logic [TS_W-1:0]   mt_time_r, mt_time_nxt, mt_dt_r, mt_dt_nxt;
  logic              mt_imp_r, mt_imp_nxt;

  status_t           status_r, status_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TAG_W-1:0]  mtag_r, mtag_nxt;
  logic [TS_W-1:0]   mtime_r, mtime_nxt, dt_r, dt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              meta_we;
  logic [PW-1:0]     meta_wa, meta_ra;
  logic [MW-1:0]     meta_wd, meta_rd;
  logic              ring_we;
  logic [RAW-1:0]    ring_wa, ring_ra;
  ring_entry_t       ring_wd, ring_rd;

  evt_class_t        cls;

  logic [TS_W-1:0]   m_time, m_dt, d_imp, new_dt;
  logic              m_imp;
  logic [CW-1:0]     m_cnt;
  logic [HW-1:0]     m_head;
  logic signed [7:0] pxl, pyl, pxh, pyh, nx, ny;
  logic signed [10:0] dx, dy;
  logic signed [21:0] dxx, dyy;
  logic [21:0]        dsq;
  logic               nb_last;

  idc_classify u_classify (
    .hit_mask    (hm_r),
    .pin1_energy (e1_r),
    .pin2_energy (e2_r),
    .pin1_th     (pin1_th_r),
    .pin2_th     (pin2_th_r),
    .cls         (cls)
  );

  idc_pixel_mem #(.DEPTH(NPIX), .AW(PW), .W(MW)) u_pixel_mem (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_wa),
    .wr_data (meta_wd),
    .rd_addr (meta_ra),
    .rd_data (meta_rd)
  );

  idc_ring_mem #(.DEPTH(RDEP), .AW(RAW)) u_ring_mem (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_wa),
    .wr_data (ring_wd),
    .rd_addr (ring_ra),
    .rd_data (ring_rd)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin1_th_r <= '0;
      pin2_th_r <= '0;
      win_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIN1_TH:  pin1_th_r <= cfg_data[E_W-1:0];
        REG_PIN2_TH:  pin2_th_r <= cfg_data[E_W-1:0];
        REG_CORR_WIN: win_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    m_head = meta_rd[HW-1:0];
    m_cnt  = meta_rd[HW+CW-1:HW];
    m_imp  = meta_rd[HW+CW];
    m_dt   = meta_rd[HW+CW+TS_W:HW+CW+1];
    m_time = meta_rd[MW-1:MW-TS_W];
    d_imp  = tdiff(ts_r, m_time);
    new_dt = m_imp ? d_imp : m_dt;
    pxl    = trunc_q4(lx_r);
    pyl    = trunc_q4(ly_r);
    pxh    = trunc_q4(hx_r);
    pyh    = trunc_q4(hy_r);
    nx     = px_r + signed'(8'(di_r)) - 8'(LIM);
    ny     = py_r + signed'(8'(dj_r)) - 8'(LIM);
    nb_last = (di_r == DW'(WS - 1)) && (dj_r == DW'(WS - 1));
    dx     = 11'(ring_rd.x_q4) - 11'(hx_r);
    dy     = 11'(ring_rd.y_q4) - 11'(hy_r);
    dxx    = dx * dx;
    dyy    = dy * dy;
    dsq    = dxx + dyy;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    clr_item_nxt = clr_item_r;
    ts_nxt = ts_r;  hm_nxt = hm_r;  e1_nxt = e1_r;  e2_nxt = e2_r;
    lx_nxt = lx_r;  ly_nxt = ly_r;  hx_nxt = hx_r;  hy_nxt = hy_r;  tag_nxt = tag_r;
    px_nxt = px_r;  py_nxt = py_r;  di_nxt = di_r;  dj_nxt = dj_r;  pix_nxt = pix_r;
    n_nxt = n_r;  k_nxt = k_r;  keep_nxt = keep_r;  h_nxt = h_r;  ev_nxt = ev_r;
    mt_time_nxt = mt_time_r;  mt_dt_nxt = mt_dt_r;  mt_imp_nxt = mt_imp_r;
    status_nxt = status_r;  cnt_nxt = cnt_r;  mtag_nxt = mtag_r;
    mtime_nxt  = mtime_r;   dt_nxt  = dt_r;
    out_valid_nxt = out_valid_r & !out_tready;
    out_data_nxt  = out_data_r;
    meta_we = 1'b0;  meta_wa = pix_r;  meta_wd = '0;  meta_ra = pix_r;
    ring_we = 1'b0;  ring_wa = '0;     ring_wd = ring_rd;  ring_ra = '0;

    unique case (state_r)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_r;
        if (clr_r == PW'(NPIX - 1)) begin
          clr_nxt   = '0;
          state_nxt = clr_item_r ? ST_CLASS : ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          ts_nxt  = in_tdata[48:1];
          hm_nxt  = in_tdata[56:49];
          e1_nxt  = in_tdata[72:57];
          e2_nxt  = in_tdata[88:73];
          lx_nxt  = signed'(in_tdata[98:89]);
          ly_nxt  = signed'(in_tdata[108:99]);
          hx_nxt  = signed'(in_tdata[118:109]);
          hy_nxt  = signed'(in_tdata[128:119]);
          tag_nxt = in_tdata[160:129];
          cnt_nxt = '0;  mtag_nxt = '0;  mtime_nxt = '0;  dt_nxt = '0;
          clr_item_nxt = in_tdata[0];
          state_nxt    = in_tdata[0] ? ST_CLEAR : ST_CLASS;
        end
      end
      ST_CLASS: begin
        state_nxt = ST_DONE;
        priority if (ts_r == '0) begin
          status_nxt = STAT_BADTIME;
        end else if (cls.implant) begin
          if (in_grid(pxl) && in_grid(pyl)) begin
            status_nxt = STAT_IMPLANT;
            meta_ra    = pix_of(pxl, pyl);
            pix_nxt    = pix_of(pxl, pyl);
            state_nxt  = ST_IMP;
          end else begin
            status_nxt = STAT_IMP_BADPOS;
          end
        end else if (cls.decay) begin
          if (in_grid(pxh) && in_grid(pyh)) begin
            status_nxt = STAT_NONE;
            px_nxt = pxh;  py_nxt = pyh;
            di_nxt = '0;   dj_nxt = '0;
            state_nxt = ST_NB;
          end else begin
            status_nxt = STAT_DEC_BADPOS;
          end
        end else if (cls.clover) begin
          status_nxt = STAT_CLOVER;
        end else if (cls.light) begin
          status_nxt = STAT_LIGHT;
        end else begin
          status_nxt = STAT_UNKNOWN;
        end
      end
      ST_IMP: begin
        state_nxt = ST_DONE;
        if (d_imp != '0) begin
          meta_we = 1'b1;
          ring_we = 1'b1;
          ring_wd = '{time_ns: ts_r, x_q4: lx_r, y_q4: ly_r, tag: tag_r};
          dt_nxt  = new_dt;
          if (m_cnt < CW'(LIST_DEPTH)) begin
            ring_wa = raddr(pix_r, slot_of(m_head, m_cnt));
            meta_wd = {ts_r, new_dt, 1'b1, CW'(m_cnt + 1'b1), m_head};
          end else begin
            ring_wa = raddr(pix_r, m_head);
            meta_wd = {ts_r, new_dt, 1'b1, m_cnt, slot_of(m_head, CW'(1))};
          end
        end
      end
      ST_NB: begin
        if (in_grid(nx) && in_grid(ny)) begin
          meta_ra   = pix_of(nx, ny);
          pix_nxt   = pix_of(nx, ny);
          state_nxt = ST_NB_META;
        end else if (nb_last) begin
          status_nxt = (cnt_r != '0) ? STAT_CORRELATED : STAT_NONE;
          state_nxt  = ST_DONE;
        end else if (dj_r == DW'(WS - 1)) begin
          dj_nxt = '0;
          di_nxt = di_r + 1'b1;
        end else begin
          dj_nxt = dj_r + 1'b1;
        end
      end
      ST_NB_META: begin
        n_nxt       = m_cnt;
        h_nxt       = m_head;
        mt_time_nxt = m_time;
        mt_dt_nxt   = m_dt;
        mt_imp_nxt  = m_imp;
        k_nxt       = '0;
        keep_nxt    = '0;
        ev_nxt      = 1'b0;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        ev_nxt = (k_r != n_r);
        if (k_r != n_r) begin
          ring_ra = raddr(pix_r, slot_of(h_r, k_r));
          k_nxt   = k_r + 1'b1;
        end
        if (ev_r && (tdiff(ts_r, ring_rd.time_ns) <= win_r)) begin
          ring_we  = 1'b1;
          ring_wa  = raddr(pix_r, slot_of(h_r, keep_r));
          keep_nxt = keep_r + 1'b1;
          if (dsq < R2) begin
            if (cnt_r != CNT_MAX) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            mtag_nxt  = ring_rd.tag;
            mtime_nxt = ring_rd.time_ns;
          end
        end
        if ((k_r == n_r) && !ev_r) begin
          state_nxt = ST_NB_WB;
        end
      end
      ST_NB_WB: begin
        meta_we = 1'b1;
        meta_wd = {mt_time_r, mt_dt_r, mt_imp_r, keep_r, h_r};
        if (nb_last) begin
          status_nxt = (cnt_r != '0) ? STAT_CORRELATED : STAT_NONE;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_NB;
          if (dj_r == DW'(WS - 1)) begin
            dj_nxt = '0;
            di_nxt = di_r + 1'b1;
          end else begin
            dj_nxt = dj_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, dt_r, mtime_r, mtag_r, cnt_r, status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ev_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
      ev_r        <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts_r <= ts_nxt;  hm_r <= hm_nxt;  e1_r <= e1_nxt;  e2_r <= e2_nxt;
    lx_r <= lx_nxt;  ly_r <= ly_nxt;  hx_r <= hx_nxt;  hy_r <= hy_nxt;  tag_r <= tag_nxt;
    px_r <= px_nxt;  py_r <= py_nxt;  di_r <= di_nxt;  dj_r <= dj_nxt;  pix_r <= pix_nxt;
    n_r <= n_nxt;  k_r <= k_nxt;  keep_r <= keep_nxt;  h_r <= h_nxt;
    mt_time_r <= mt_time_nxt;  mt_dt_r <= mt_dt_nxt;  mt_imp_r <= mt_imp_nxt;
    status_r <= status_nxt;  cnt_r <= cnt_nxt;  mtag_r <= mtag_nxt;
    mtime_r  <= mtime_nxt;   dt_r  <= dt_nxt;
    out_data_r <= out_data_nxt;
  end

  `IDC_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (state_r == ST_CLEAR && !out_valid_r), "reset did not start the clearing sweep")
  `IDC_ASSERT(a_keep_le_read, clk, rst_n, (state_r == ST_SCAN) |-> (keep_r <= k_r && k_r <= n_r), "compaction index passed read index")
  `IDC_ASSERT(a_list_bound, clk, rst_n, (state_r == ST_SCAN) |-> (n_r <= CW'(LIST_DEPTH)), "pixel list fill exceeds depth")
  `IDC_ASSERT(a_corr_count, clk, rst_n, (out_valid_r && out_data_r[3:0] == STAT_CORRELATED) |-> (out_data_r[10:4] != '0), "correlated result with zero count")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

import idc_pkg::*;

typedef struct {
  bit                    clr;
  logic [TS_W-1:0]       ts;
  logic [HM_W-1:0]       hm;
  logic [E_W-1:0]        e1;
  logic [E_W-1:0]        e2;
  logic signed [POS_W-1:0] lx;
  logic signed [POS_W-1:0] ly;
  logic signed [POS_W-1:0] hx;
  logic signed [POS_W-1:0] hy;
  logic [TAG_W-1:0]      tag;
} event_t;

typedef struct {
  status_t           status;
  logic [CNT_W-1:0]  count;
  logic [TAG_W-1:0]  mtag;
  logic [TS_W-1:0]   mtime;
  logic [TS_W-1:0]   dt;
} verdict_t;

class correlator_scoreboard;
  localparam int NG = 16;
  localparam int NPIX = NG * NG;
  localparam int DEPTH = 8;
  localparam int HALF = 1;

  logic [TS_W-1:0]  pix_time[NPIX];
  bit               pix_seen[NPIX];
  logic [TS_W-1:0]  pix_dt[NPIX];
  logic [TS_W-1:0]  list_time[NPIX*DEPTH];
  int               list_x[NPIX*DEPTH];
  int               list_y[NPIX*DEPTH];
  logic [TAG_W-1:0] list_tag[NPIX*DEPTH];
  int               list_cnt[NPIX];
  int               list_head[NPIX];
  logic [E_W-1:0]   th1, th2;
  logic [TS_W-1:0]  window;
  verdict_t         pending[$];
  int               mismatches;

  function new();
    wipe();
    th1 = 0;
    th2 = 0;
    window = 0;
    mismatches = 0;
  endfunction

  function void wipe();
    for (int p = 0; p < NPIX; p++) begin
      pix_time[p] = 0;
      pix_seen[p] = 0;
      pix_dt[p] = 0;
      list_cnt[p] = 0;
      list_head[p] = 0;
    end
  endfunction

  function logic [TS_W-1:0] gap_of(logic [TS_W-1:0] a, logic [TS_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function void note_event(event_t ev);
    verdict_t v;
    bit low, high, p1, p2, vf, vr, sipm, clov;
    bit any_pin, pin_imp, pin_light, is_imp, is_light, is_decay, is_clov;
    int xq, yq, px, py, pix, n, h, idx, keep, dx, dy, nx, ny, cnt;
    v = '{STAT_BADTIME, 0, 0, 0, 0};
    if (ev.clr) wipe();
    low = ev.hm[HM_LOW];
    high = ev.hm[HM_HIGH];
    p1 = ev.hm[HM_PIN1];
    p2 = ev.hm[HM_PIN2];
    vf = ev.hm[HM_VETOF];
    vr = ev.hm[HM_VETOR];
    sipm = ev.hm[HM_SIPM];
    clov = ev.hm[HM_CLOV];
    any_pin = p1 || p2;
    pin_imp = p1 && ev.e1 > th1 && p2 && ev.e2 > th2;
    pin_light = p1 && !(ev.e1 > th1) && p2 && !(ev.e2 > th2);
    is_imp = low && pin_imp && !vr;
    is_light = (low || high) && (pin_light || vf || vr || sipm);
    is_decay = high && !any_pin && !is_light;
    is_clov = !any_pin && !high && !low && clov;
    if (ev.ts == 0) begin
      v.status = STAT_BADTIME;
    end else if (is_imp) begin
      xq = ev.lx;
      yq = ev.ly;
      px = xq / 16;
      py = yq / 16;
      if (px < 0 || px >= NG || py < 0 || py >= NG) begin
        v.status = STAT_IMP_BADPOS;
      end else begin
        pix = px * NG + py;
        v.status = STAT_IMPLANT;
        if (gap_of(ev.ts, pix_time[pix]) != 0) begin
          if (pix_seen[pix]) pix_dt[pix] = gap_of(ev.ts, pix_time[pix]);
          else pix_seen[pix] = 1;
          pix_time[pix] = ev.ts;
          n = list_cnt[pix];
          h = list_head[pix];
          if (n < DEPTH) begin
            idx = pix * DEPTH + (h + n) % DEPTH;
            list_cnt[pix] = n + 1;
          end else begin
            idx = pix * DEPTH + h;
            list_head[pix] = (h + 1) % DEPTH;
          end
          list_time[idx] = ev.ts;
          list_x[idx] = xq;
          list_y[idx] = yq;
          list_tag[idx] = ev.tag;
          v.dt = pix_dt[pix];
        end
      end
    end else if (is_decay) begin
      xq = ev.hx;
      yq = ev.hy;
      px = xq / 16;
      py = yq / 16;
      if (px < 0 || px >= NG || py < 0 || py >= NG) begin
        v.status = STAT_DEC_BADPOS;
      end else begin
        cnt = 0;
        for (int i = -HALF; i <= HALF; i++) begin
          for (int j = -HALF; j <= HALF; j++) begin
            nx = px + i;
            ny = py + j;
            if (nx < 0 || nx >= NG || ny < 0 || ny >= NG) continue;
            pix = nx * NG + ny;
            n = list_cnt[pix];
            h = list_head[pix];
            keep = 0;
            for (int k = 0; k < n; k++) begin
              int src, dst;
              src = pix * DEPTH + (h + k) % DEPTH;
              if (gap_of(ev.ts, list_time[src]) > window) continue;
              dst = pix * DEPTH + (h + keep) % DEPTH;
              list_time[dst] = list_time[src];
              list_x[dst] = list_x[src];
              list_y[dst] = list_y[src];
              list_tag[dst] = list_tag[src];
              keep++;
              dx = list_x[dst] - xq;
              dy = list_y[dst] - yq;
              if (dx * dx + dy * dy < 256 * HALF * HALF) begin
                if (cnt < 127) cnt++;
                v.mtag = list_tag[dst];
                v.mtime = list_time[dst];
              end
            end
            list_cnt[pix] = keep;
          end
        end
        v.count = CNT_W'(cnt);
        v.status = cnt > 0 ? STAT_CORRELATED : STAT_NONE;
      end
    end else if (is_clov) begin
      v.status = STAT_CLOVER;
    end else if (is_light) begin
      v.status = STAT_LIGHT;
    end else begin
      v.status = STAT_UNKNOWN;
    end
    pending.insert(pending.size(), v);
  endfunction

  function void check_result(logic [OUT_W-1:0] d);
    verdict_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", d);
      return;
    end
    e = pending.pop_front();
    if (d[3:0] !== e.status || d[10:4] !== e.count || d[42:11] !== e.mtag ||
        d[90:43] !== e.mtime || d[138:91] !== e.dt) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st=%0d n=%0d tag=%h t=%h dt=%h got st=%0d n=%0d tag=%h t=%h dt=%h",
                 e.status, e.count, e.mtag, e.mtime, e.dt,
                 d[3:0], d[10:4], d[42:11], d[90:43], d[138:91]);
    end
  endfunction
endclass

module tb_top;
  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_valid, cfg_ready;
  logic [IN_W-1:0]  in_tdata;
  logic [OUT_W-1:0] out_tdata;
  reg_idx_t         cfg_index;
  logic [TS_W-1:0]  cfg_data;

  correlator_scoreboard sb;
  bit calm, hold_req, held;
  logic [TS_W-1:0] clock_ns;
  logic [TS_W-1:0] last_imp_ts;
  logic signed [POS_W-1:0] last_imp_x, last_imp_y;
  int idle_cycles;

  implant_decay_correlator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic event_t decode_event(logic [IN_W-1:0] d);
    event_t ev;
    ev.clr = d[0];
    ev.ts = d[48:1];
    ev.hm = d[56:49];
    ev.e1 = d[72:57];
    ev.e2 = d[88:73];
    ev.lx = d[98:89];
    ev.ly = d[108:99];
    ev.hx = d[118:109];
    ev.hy = d[128:119];
    ev.tag = d[160:129];
    return ev;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_event(decode_event(in_tdata));
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        held = 1;
        out_tready <= 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_event(event_t ev);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {7'd0, ev.tag, ev.hy, ev.hx, ev.ly, ev.lx, ev.e2, ev.e1, ev.hm, ev.ts, ev.clr};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [TS_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PIN1_TH:  sb.th1 = val[E_W-1:0];
      REG_PIN2_TH:  sb.th2 = val[E_W-1:0];
      REG_CORR_WIN: sb.window = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_phase(logic [E_W-1:0] a, logic [E_W-1:0] b, logic [TS_W-1:0] w);
    write_reg(REG_PIN1_TH, TS_W'(a));
    write_reg(REG_PIN2_TH, TS_W'(b));
    write_reg(REG_CORR_WIN, w);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 767) - 256);
    return POS_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [E_W-1:0] above(logic [E_W-1:0] th);
    if (th == 16'hFFFF) return 16'hFFFF;
    return E_W'($urandom_range(th + 1, 65535));
  endfunction

  function automatic event_t make_event(int kind);
    event_t ev;
    int r;
    r = $urandom_range(0, 39);
    clock_ns += TS_W'($urandom_range(1, 400));
    ev.clr = ($urandom_range(0, 99) == 0);
    ev.ts = clock_ns;
    if (r == 0) ev.ts = 0;
    else if (r == 1) ev.ts = TS_W'({$urandom, $urandom});
    ev.e1 = E_W'($urandom);
    ev.e2 = E_W'($urandom);
    ev.lx = pick_pos();
    ev.ly = pick_pos();
    ev.hx = pick_pos();
    ev.hy = pick_pos();
    ev.tag = $urandom;
    ev.hm = HM_W'($urandom);
    if (kind == 0) begin
      ev.hm[HM_LOW] = 1;
      ev.hm[HM_PIN1] = 1;
      ev.hm[HM_PIN2] = 1;
      ev.hm[HM_VETOR] = 0;
      ev.e1 = above(sb.th1);
      ev.e2 = above(sb.th2);
      if (r == 2) begin
        ev.ts = last_imp_ts;
        ev.lx = last_imp_x;
        ev.ly = last_imp_y;
      end
      last_imp_ts = ev.ts;
      last_imp_x = ev.lx;
      last_imp_y = ev.ly;
    end else if (kind == 1) begin
      ev.hm[HM_HIGH] = 1;
      ev.hm[HM_PIN1] = 0;
      ev.hm[HM_PIN2] = 0;
      ev.hm[HM_VETOF] = 0;
      ev.hm[HM_VETOR] = 0;
      ev.hm[HM_SIPM] = 0;
    end
    return ev;
  endfunction

  task automatic run_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      send_event(make_event(k < 5 ? 0 : (k < 8 ? 1 : 2)));
    end
  endtask

  task automatic directed();
    event_t ev;
    ev = '{1, 0, 8'h07, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 32'hFFFFFFFF};
    send_event(ev);
    ev.clr = 0;
    ev.ts = 48'd100;
    ev.lx = 10'sd0; ev.ly = 10'sd0;
    send_event(ev);
    ev.ts = 48'd100;
    send_event(ev);
    ev.ts = 48'd150; ev.tag = 0;
    send_event(ev);
    ev.ts = 48'd160; ev.lx = 10'sd255; ev.ly = 10'sd255;
    send_event(ev);
    ev.lx = 10'sd256;
    send_event(ev);
    ev.lx = -10'sd256; ev.ly = -10'sd15;
    send_event(ev);
    ev.lx = -10'sd15; ev.ly = 10'sd511; ev.ts = 48'd170;
    send_event(ev);
    ev.lx = 10'sd8; ev.ly = 10'sd8; ev.ts = 48'd180;
    send_event(ev);
    for (int i = 0; i < 9; i++) begin
      ev.ts = 48'd190 + TS_W'(i);
      ev.tag = 32'hA000 + TAG_W'(i);
      send_event(ev);
    end
    ev = '{0, 48'd200, 8'h02, 0, 0, 0, 0, 10'sd8, 10'sd8, 0};
    send_event(ev);
    ev.hx = 10'sd24; ev.hy = 10'sd24; ev.hm = 8'hC3;
    send_event(ev);
    ev.hx = -10'sd256; ev.hy = 10'sd511;
    send_event(ev);
    ev.hx = 10'sd250;
    send_event(ev);
    ev = '{0, 48'hFFFFFFFFFFFF, 8'h80, 0, 0, 0, 0, 0, 0, 0};
    send_event(ev);
    ev.hm = 8'h0D; ev.e1 = 0; ev.e2 = 0;
    send_event(ev);
    ev.hm = 8'h11;
    send_event(ev);
    ev.hm = 8'h00;
    send_event(ev);
    ev.hm = 8'h2D; ev.e1 = 16'hFFFF; ev.e2 = 16'hFFFF;
    send_event(ev);
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = REG_PIN1_TH;
    cfg_data = '0;
    calm = 0;
    hold_req = 0;
    clock_ns = 48'd1000;
    last_imp_ts = 48'd1000;
    last_imp_x = 0;
    last_imp_y = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    set_phase(0, 0, 48'd1000);
    directed();
    run_random(100);
    drain();
    set_phase(16'd30000, 16'd20000, 48'd500);
    hold_req = 1;
    run_random(110);
    drain();
    set_phase(16'hFFFF, 16'hFFFF, 48'hFFFFFFFFFFFF);
    run_random(100);
    drain();
    set_phase(16'd100, 16'd200, 48'd0);
    run_random(100);
    drain();
    set_phase(16'd1000, 16'd1000, 48'd2000);
    calm = 1;
    run_random(110);
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/idc_pkg.sv
rtl/idc_classify.sv
rtl/idc_pixel_mem.sv
rtl/idc_ring_mem.sv
rtl/implant_decay_correlator_unit.sv
tb/tb_top.sv
